### hdl/path_following_steering_control_core_macros.svh
// ----------------------------------------------------------------------------
// Steering control core assertion macros
// Shorthand for clocked checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PATH_FOLLOWING_STEERING_CONTROL_CORE_MACROS_SVH
`define PATH_FOLLOWING_STEERING_CONTROL_CORE_MACROS_SVH

// same-cycle implication
`define PFSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steering core check failed");

// next-cycle implication
`define PFSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steering core check failed");

`endif

### hdl/pfsc_pkg.sv
// ----------------------------------------------------------------------------
// Steering control package
// Fixed-point constants, register indexes, arctan table and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
  localparam int RED_STEPS    = 30 - FRAC_BITS;

  localparam logic signed [33:0] Q_ONE      = 34'sh1 << FRAC_BITS;
  localparam logic [31:0]        TIME_LIMIT = 32'd25 << FRAC_BITS;

  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] CFG_INT_GAIN   = 3'd1;
  localparam logic [2:0] CFG_LAT_GAIN   = 3'd2;
  localparam logic [2:0] CFG_HEAD_GAIN  = 3'd3;
  localparam logic [2:0] CFG_STEP_TIME  = 3'd4;
  localparam logic [2:0] CFG_TGT_SPEED  = 3'd5;
  localparam logic [2:0] CFG_TURN_CURV  = 3'd6;
  localparam logic [2:0] CFG_TURN_START = 3'd7;

  typedef struct packed {
    logic signed [33:0] s;
    logic signed [33:0] c;
  } trig_t;

  function automatic logic [31:0] atan_q30(input logic [CORDIC_IW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/pfsc_cordic.sv
// ----------------------------------------------------------------------------
// Steering control sine/cosine unit
// Range reduction by shifted subtraction, quadrant fold, then one CORDIC
// rotation per cycle on Q30 values.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsc_cordic import pfsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output trig_t              trig
);

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_RED  = 4'b0010,
    CS_FOLD = 4'b0100,
    CS_ROT  = 4'b1000
  } cs_t;

  localparam int KW = $clog2(RED_STEPS);

  cs_t st_r, st_nxt;
  logic done_r, done_nxt;
  logic [63:0] r_r;
  logic neg_r, flip_r;
  logic [KW-1:0] k_r;
  logic [CORDIC_IW-1:0] i_r;
  logic signed [33:0] x_r, y_r, z_r;

  logic signed [63:0] zin, zs, zf;
  logic [63:0] absz, cand, m;
  logic signed [33:0] dx, dy, atn;

  always_comb begin
    zin  = 64'(angle) <<< (30 - FRAC_BITS);
    absz = zin[63] ? -zin : zin;
    cand = Q30_TWO_PI << k_r;
    m    = (neg_r && r_r != 64'd0) ? Q30_TWO_PI - r_r : r_r;
    zs   = $signed(m) - ((m >= Q30_PI) ? $signed(Q30_TWO_PI) : 64'sd0);
    if (zs > $signed(Q30_HALF_PI)) zf = $signed(Q30_PI) - zs;
    else if (zs < -$signed(Q30_HALF_PI)) zf = -$signed(Q30_PI) - zs;
    else zf = zs;
    dx  = y_r >>> i_r;
    dy  = x_r >>> i_r;
    atn = $signed({2'b00, atan_q30(i_r)});
  end

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    unique case (st_r)
      CS_IDLE: if (start) st_nxt = CS_RED;
      CS_RED:  if (k_r == '0) st_nxt = CS_FOLD;
      CS_FOLD: st_nxt = CS_ROT;
      CS_ROT: begin
        if (i_r == CORDIC_IW'(CORDIC_STEPS - 1)) begin
          st_nxt   = CS_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      CS_IDLE: begin
        r_r   <= absz;
        neg_r <= zin[63];
        k_r   <= KW'(RED_STEPS - 1);
      end
      CS_RED: begin
        if (r_r >= cand) r_r <= r_r - cand;
        k_r <= k_r - KW'(1);
      end
      CS_FOLD: begin
        z_r    <= zf[33:0];
        flip_r <= (zs > $signed(Q30_HALF_PI)) || (zs < -$signed(Q30_HALF_PI));
        x_r    <= CORDIC_GAIN;
        y_r    <= 34'sd0;
        i_r    <= '0;
      end
      CS_ROT: begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atn;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atn;
        end
        i_r <= i_r + CORDIC_IW'(1);
      end
      default: ;
    endcase
  end

  assign done   = done_r;
  assign trig.s = y_r;
  assign trig.c = flip_r ? -x_r : x_r;

endmodule

`default_nettype wire

### hdl/pfsc_div.sv
// ----------------------------------------------------------------------------
// Steering control divider
// Restoring division, one quotient bit per cycle, truncating toward zero,
// with saturation and a fixed answer for a zero divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsc_div import pfsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [33:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_RUN  = 3'b010,
    DS_FIN  = 3'b100
  } ds_t;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam int RW = 35;

  ds_t st_r, st_nxt;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] n_r, q_r;
  logic [RW-1:0] rem_r, d_r;
  logic neg_r, zero_r, nneg_r;

  logic signed [32:0] nx, absn;
  logic signed [33:0] absd;
  logic [RW-1:0] sh;

  always_comb begin
    nx   = 33'(num);
    absn = nx[32] ? -nx : nx;
    absd = den[33] ? -den : den;
    sh   = {rem_r[RW-2:0], n_r[DW-1]};
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DS_IDLE: if (start) st_nxt = (den == 34'sd0) ? DS_FIN : DS_RUN;
      DS_RUN:  if (cnt_r == CW'(DW - 1)) st_nxt = DS_FIN;
      DS_FIN:  st_nxt = DS_IDLE;
      default: st_nxt = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= DS_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      DS_IDLE: begin
        n_r    <= DW'(unsigned'(absn)) << FRAC_BITS;
        d_r    <= RW'(unsigned'(absd));
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
        neg_r  <= num[31] ^ den[33];
        zero_r <= (den == 34'sd0);
        nneg_r <= !num[31];
      end
      DS_RUN: begin
        if (sh >= d_r) begin
          rem_r <= sh - d_r;
          q_r   <= {q_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[DW-2:0], 1'b0};
        end
        n_r   <= {n_r[DW-2:0], 1'b0};
        cnt_r <= cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (zero_r) quo = nneg_r ? 32'sh7FFFFFFF : 32'sh80000000;
    else if (neg_r) quo = (q_r > DW'(32'h80000000)) ? 32'sh80000000 : -$signed(q_r[31:0]);
    else quo = (q_r > DW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(q_r[31:0]);
  end

  assign done = (st_r == DS_FIN);

endmodule

`default_nettype wire

### hdl/path_following_steering_control_core.sv
// ----------------------------------------------------------------------------
// Path-following steering control core
// Kinematic reference path generator with a PI yaw-rate steering loop.
// ----------------------------------------------------------------------------
// One word is taken at a time and in_stall stays high until its result is
// in the output register. A state sample passes through the sine/cosine
// unit (launch, range reduction, fold, rotation and done), and a control
// tick passes through it and then through the divider (launch, quotient
// bits and finish, with the quotient bits skipped when the curvature
// denominator is exactly zero). Every product goes through the single
// shared 34x34 multiplier and is registered before it is written back.
// A result held by out_stall stretches the last cycle. All port values are
// Q16.16.
`default_nettype none

module path_following_steering_control_core import pfsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [31:0] in_meas_x,
  input  logic signed [31:0] in_meas_y,
  input  logic signed [31:0] in_meas_heading,
  input  logic signed [31:0] in_meas_speed,
  input  logic signed [31:0] in_meas_yaw_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [31:0] out_ref_x,
  output logic signed [31:0] out_ref_y,
  output logic signed [31:0] out_ref_heading,
  output logic signed [31:0] out_ref_yaw_rate,
  output logic signed [31:0] out_steer_cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LAUNCH = 6'b000010,
    ST_WB     = 6'b000100,
    ST_TRIG   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_OUT    = 6'b100000
  } st_t;

  typedef enum logic [4:0] {
    P_YAW, P_HEAD, P_TRIG, P_XA, P_XB, P_YA, P_YB, P_LA, P_LB,
    T_YAW, T_TRIG, T_DEN, T_NUM, T_DIV, T_CA, T_BA, T_BB, T_CC, T_INT, T_PA, T_PB
  } upc_t;

  st_t  st_r, st_nxt;
  upc_t uc_r;

  logic [30:0] prop_r, igain_r, lgain_r, hgain_r;
  logic [16:0] step_r;
  logic signed [31:0] tgt_r, turn_r;
  logic [20:0] tstart_r;

  logic [31:0] elapsed_r;
  logic signed [31:0] curv_r, refh_r, refx_r, refy_r, laterr_r, headerr_r;
  logic signed [31:0] lspeed_r, lyaw_r, integ_r;

  logic op_r;
  logic signed [31:0] mx_r, my_r, mh_r, yr_r, t0_r, t1_r, t2_r, num_r, quo_r, ew_r, steer_r;
  logic signed [37:0] acc_r;
  logic signed [33:0] den_r, s_r, c_r;
  logic signed [67:0] prod_r;
  logic out_valid_r;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod, q30w;
  logic signed [31:0] q16, q30, ew_calc, quo;
  logic signed [71:0] corr;
  logic [32:0] tsum;
  logic [31:0] tnew;
  logic accept, trig_start, div_start, trig_done, div_done, last_step, out_load;
  logic signed [31:0] trig_angle;
  trig_t trig;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (st_r != ST_IDLE);
  assign last_step  = (uc_r == P_LB) || (uc_r == T_PB);
  assign out_load   = (st_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign trig_angle = (uc_r == P_TRIG) ? refh_r : headerr_r;

  always_comb begin
    tsum = 33'(elapsed_r) + 33'(step_r);
    tnew = (tsum >= 33'(TIME_LIMIT)) ? TIME_LIMIT : tsum[31:0];
  end

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    case (uc_r)
      P_YAW, T_YAW: begin mul_a = 34'(curv_r); mul_b = 34'(tgt_r); end
      P_HEAD: begin mul_a = 34'(yr_r); mul_b = $signed({17'd0, step_r}); end
      P_XA:   begin mul_a = c_r; mul_b = 34'(tgt_r); end
      P_XB, P_YB: begin mul_a = 34'(t0_r); mul_b = $signed({17'd0, step_r}); end
      P_YA:   begin mul_a = s_r; mul_b = 34'(tgt_r); end
      P_LA:   begin mul_a = -s_r; mul_b = 34'(mx_r) - 34'(refx_r); end
      P_LB:   begin mul_a = c_r; mul_b = 34'(my_r) - 34'(refy_r); end
      T_DEN:  begin mul_a = 34'(laterr_r); mul_b = 34'(curv_r); end
      T_NUM:  begin mul_a = c_r; mul_b = 34'(lspeed_r); end
      T_CA:   begin mul_a = 34'(curv_r); mul_b = 34'(quo_r); end
      T_BA:   begin mul_a = 34'(laterr_r); mul_b = $signed({3'd0, lgain_r}); end
      T_BB:   begin mul_a = 34'(t1_r); mul_b = 34'(lspeed_r); end
      T_CC:   begin mul_a = s_r; mul_b = $signed({3'd0, hgain_r}); end
      T_INT:  begin mul_a = 34'(ew_r); mul_b = $signed({17'd0, step_r}); end
      T_PA:   begin mul_a = $signed({3'd0, prop_r}); mul_b = 34'(ew_r); end
      T_PB:   begin mul_a = $signed({3'd0, igain_r}); mul_b = 34'(integ_r); end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    q30w    = prod_r >>> 30;
    q16     = sat32(72'(prod_r >>> FRAC_BITS));
    q30     = sat32(72'(q30w));
    corr    = 72'(t0_r) - 72'(t2_r) - 72'(q30);
    ew_calc = sat32(72'(sat32(corr)) - 72'(lyaw_r));
  end

  always_comb begin
    st_nxt     = st_r;
    trig_start = 1'b0;
    div_start  = 1'b0;
    unique case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_LAUNCH;
      ST_LAUNCH: begin
        if (uc_r == P_TRIG || uc_r == T_TRIG) begin
          trig_start = 1'b1;
          st_nxt     = ST_TRIG;
        end else if (uc_r == T_DIV) begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end else begin
          st_nxt = ST_WB;
        end
      end
      ST_WB:   st_nxt = last_step ? ST_OUT : ST_LAUNCH;
      ST_TRIG: if (trig_done) st_nxt = ST_LAUNCH;
      ST_DIV:  if (div_done) st_nxt = ST_LAUNCH;
      ST_OUT:  if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // configuration and architected state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r    <= 31'd13107;
      igain_r   <= 31'd19661;
      lgain_r   <= 31'd19661;
      hgain_r   <= 31'd19661;
      step_r    <= 17'd3277;
      tgt_r     <= 32'sd327680;
      turn_r    <= 32'sd3277;
      tstart_r  <= 21'd983040;
      elapsed_r <= '0;
      curv_r    <= '0;
      refh_r    <= '0;
      refx_r    <= '0;
      refy_r    <= '0;
      laterr_r  <= '0;
      headerr_r <= '0;
      lspeed_r  <= '0;
      lyaw_r    <= '0;
      integ_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PROP_GAIN:  prop_r   <= cfg_wdata[30:0];
          CFG_INT_GAIN:   igain_r  <= cfg_wdata[30:0];
          CFG_LAT_GAIN:   lgain_r  <= cfg_wdata[30:0];
          CFG_HEAD_GAIN:  hgain_r  <= cfg_wdata[30:0];
          CFG_STEP_TIME:  step_r   <= cfg_wdata[16:0];
          CFG_TGT_SPEED:  tgt_r    <= $signed(cfg_wdata);
          CFG_TURN_CURV:  turn_r   <= $signed(cfg_wdata);
          CFG_TURN_START: tstart_r <= cfg_wdata[20:0];
          default: ;
        endcase
      end
      if (accept && in_op == OP_SAMPLE) begin
        lspeed_r  <= in_meas_speed;
        lyaw_r    <= in_meas_yaw_rate;
        elapsed_r <= tnew;
        curv_r    <= (tnew > 32'(tstart_r) && tnew < TIME_LIMIT) ? turn_r : 32'sd0;
      end
      if (st_r == ST_WB) begin
        case (uc_r)
          P_HEAD: refh_r <= sat32(72'(refh_r) + 72'(q16));
          P_XB:   refx_r <= sat32(72'(refx_r) + 72'(q16));
          P_YB:   refy_r <= sat32(72'(refy_r) + 72'(q16));
          P_LB: begin
            laterr_r  <= sat32(72'(acc_r) + 72'(q30w));
            headerr_r <= sat32(72'(mh_r) - 72'(refh_r));
          end
          T_INT:  integ_r <= sat32(72'(integ_r) + 72'(q16));
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (accept) begin
      op_r <= in_op;
      mx_r <= in_meas_x;
      my_r <= in_meas_y;
      mh_r <= in_meas_heading;
      uc_r <= (in_op == OP_TICK) ? T_YAW : P_YAW;
    end
    if ((st_r == ST_WB && !last_step) || (st_r == ST_TRIG && trig_done)
        || (st_r == ST_DIV && div_done)) begin
      uc_r <= upc_t'(uc_r + 5'd1);
    end
    if (st_r == ST_TRIG && trig_done) begin
      s_r <= trig.s;
      c_r <= trig.c;
    end
    if (st_r == ST_DIV && div_done) quo_r <= quo;
    if (st_r == ST_WB) begin
      case (uc_r)
        P_YAW, T_YAW: yr_r <= q16;
        P_XA, P_YA:   t0_r <= q30;
        P_LA:   acc_r <= q30w[37:0];
        T_DEN:  den_r <= Q_ONE - 34'(q16);
        T_NUM:  num_r <= q30;
        T_CA:   t0_r <= q16;
        T_BA:   t1_r <= q16;
        T_BB:   t2_r <= q16;
        T_CC:   ew_r <= ew_calc;
        T_PA:   t0_r <= q16;
        T_PB:   steer_r <= sat32(72'(t0_r) + 72'(q16));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind         <= op_r;
      out_ref_x        <= refx_r;
      out_ref_y        <= refy_r;
      out_ref_heading  <= refh_r;
      out_ref_yaw_rate <= yr_r;
      out_steer_cmd    <= (op_r == OP_TICK) ? steer_r : 32'sd0;
    end
  end

  assign out_valid = out_valid_r;

  pfsc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (trig_angle),
    .done  (trig_done),
    .trig  (trig)
  );

  pfsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

endmodule

`default_nettype wire

### hdl/pfsc_checker.sv
// ----------------------------------------------------------------------------
// Steering control port checker
// Watches the core's ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "path_following_steering_control_core_macros.svh"

module pfsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_op,
  input logic [31:0] in_meas_x,
  input logic [31:0] in_meas_y,
  input logic [31:0] in_meas_heading,
  input logic [31:0] in_meas_speed,
  input logic [31:0] in_meas_yaw_rate,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [31:0] out_ref_x,
  input logic [31:0] out_ref_y,
  input logic [31:0] out_ref_heading,
  input logic [31:0] out_ref_yaw_rate,
  input logic [31:0] out_steer_cmd,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_wdata
);

  `PFSC_ASSERT_NEXT(busy_after_accept, in_valid && !in_stall, in_stall)
  `PFSC_ASSERT_NEXT(no_instant_result, in_valid && !in_stall && !out_valid, !out_valid)
  `PFSC_ASSERT_SAME(sample_no_steer, out_valid && !out_kind, out_steer_cmd == 32'd0)
  `PFSC_ASSERT_NEXT(out_hold, out_valid && out_stall, out_valid && $stable(out_ref_x))

endmodule

bind path_following_steering_control_core pfsc_checker u_pfsc_checker (.*);

`default_nettype wire

### tb/path_following_steering_control_core_tb.sv
// ----------------------------------------------------------------------------
// Steering control core testbench
// Drives state samples and control ticks with random gaps and stalls, with
// register settings changed between phases, and checks every result word
// against a fixed-point predictor of the reference path and PI steering loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_following_steering_control_core_tb;
  import pfsc_pkg::*;

  typedef struct {
    logic               kind;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_heading;
    logic signed [31:0] ref_yaw_rate;
    logic signed [31:0] steer_cmd;
  } steer_word_t;

  localparam longint TWO_PI  = 64'd6746518852;
  localparam longint PI_Q30  = 64'd3373259426;
  localparam longint HALF_PI = 64'd1686629713;
  localparam longint GAIN_Q30 = 64'd652032874;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint fshift(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qm(input longint a, input longint b);
    return sat(fshift(a * b, FRAC_BITS));
  endfunction

  function automatic longint tm(input longint t, input longint v);
    return fshift(t * v, 30);
  endfunction

  function automatic longint arctan_at(input int i);
    longint tbl[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  task automatic rotate(input longint ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * (64'sd1 << (30 - FRAC_BITS));
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    z = z % TWO_PI;
    if (z < 0) z += TWO_PI;
    if (z >= PI_Q30) z -= TWO_PI;
    if (z > HALF_PI) begin
      z = PI_Q30 - z;
      flip = 1;
    end else if (z < -HALF_PI) begin
      z = -PI_Q30 - z;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_at(i);
      end else begin
        x += dx; y -= dy; z += arctan_at(i);
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  class steer_scoreboard;
    longint gain_p, gain_i, gain_lat, gain_head, dt, speed_tgt, curv_turn, t_turn;
    longint elapsed, curv, head_ref, x_ref, y_ref, e_lat, e_head, v_meas, w_meas, integ;
    steer_word_t pending[$];

    function new();
      gain_p = 13107; gain_i = 19661; gain_lat = 19661; gain_head = 19661;
      dt = 3277; speed_tgt = 327680; curv_turn = 3277; t_turn = 983040;
      elapsed = 0; curv = 0; head_ref = 0; x_ref = 0; y_ref = 0;
      e_lat = 0; e_head = 0; v_meas = 0; w_meas = 0; integ = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
        CFG_PROP_GAIN:  gain_p = v[30:0];
        CFG_INT_GAIN:   gain_i = v[30:0];
        CFG_LAT_GAIN:   gain_lat = v[30:0];
        CFG_HEAD_GAIN:  gain_head = v[30:0];
        CFG_STEP_TIME:  dt = v[16:0];
        CFG_TGT_SPEED:  speed_tgt = $signed(v);
        CFG_TURN_CURV:  curv_turn = $signed(v);
        CFG_TURN_START: t_turn = v[20:0];
        default: ;
      endcase
    endfunction

    task note_input(input logic op, input logic signed [31:0] mx, my, mh, ms, mw);
      steer_word_t w;
      longint s, c, lim, t, den, num, quo, corr, ew, steer;
      steer = 0;
      lim = 25 * (64'sd1 << FRAC_BITS);
      if (op == OP_SAMPLE) begin
        v_meas = ms;
        w_meas = mw;
        t = elapsed + dt;
        if (t >= lim) t = lim;
        elapsed = sat(t);
        curv = (elapsed > t_turn && elapsed < lim) ? curv_turn : 0;
        head_ref = sat(head_ref + qm(qm(curv, speed_tgt), dt));
        rotate(head_ref, s, c);
        x_ref = sat(x_ref + qm(sat(tm(c, speed_tgt)), dt));
        y_ref = sat(y_ref + qm(sat(tm(s, speed_tgt)), dt));
        e_lat = sat(tm(-s, longint'(mx) - x_ref) + tm(c, longint'(my) - y_ref));
        e_head = sat(longint'(mh) - head_ref);
      end else begin
        rotate(e_head, s, c);
        den = (64'sd1 << FRAC_BITS) - qm(e_lat, curv);
        num = sat(tm(c, v_meas));
        if (den == 0) quo = num >= 0 ? 64'sd2147483647 : -64'sd2147483648;
        else quo = sat((num * (64'sd1 << FRAC_BITS)) / den);
        corr = qm(curv, quo) - qm(qm(e_lat, gain_lat), v_meas) - sat(tm(s, gain_head));
        ew = sat(sat(corr) - w_meas);
        integ = sat(integ + qm(ew, dt));
        steer = sat(qm(gain_p, ew) + qm(gain_i, integ));
      end
      w.kind = op;
      w.ref_x = x_ref;
      w.ref_y = y_ref;
      w.ref_heading = head_ref;
      w.ref_yaw_rate = qm(curv, speed_tgt);
      w.steer_cmd = steer;
      pending.push_back(w);
    endtask

    task check_result(input steer_word_t got);
      steer_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = pending.pop_front();
        if (got.kind !== e.kind) report("kind", got.kind, e.kind);
        if (got.ref_x !== e.ref_x) report("ref_x", got.ref_x, e.ref_x);
        if (got.ref_y !== e.ref_y) report("ref_y", got.ref_y, e.ref_y);
        if (got.ref_heading !== e.ref_heading)
          report("ref_heading", got.ref_heading, e.ref_heading);
        if (got.ref_yaw_rate !== e.ref_yaw_rate)
          report("ref_yaw_rate", got.ref_yaw_rate, e.ref_yaw_rate);
        if (got.steer_cmd !== e.steer_cmd)
          report("steer_cmd", got.steer_cmd, e.steer_cmd);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_op = 0;
  logic signed [31:0] in_meas_x = 0, in_meas_y = 0, in_meas_heading = 0;
  logic signed [31:0] in_meas_speed = 0, in_meas_yaw_rate = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_kind;
  logic signed [31:0] out_ref_x, out_ref_y, out_ref_heading, out_ref_yaw_rate;
  logic signed [31:0] out_steer_cmd;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  steer_scoreboard sb = new();
  int n_samples = 0, n_ticks = 0, n_results = 0;
  bit rx_free = 0;

  always #5 clk = ~clk;

  path_following_steering_control_core DUT (.*);

  always @(posedge clk) begin
    steer_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      w.kind = out_kind;
      w.ref_x = out_ref_x;
      w.ref_y = out_ref_y;
      w.ref_heading = out_ref_heading;
      w.ref_yaw_rate = out_ref_yaw_rate;
      w.steer_cmd = out_steer_cmd;
      sb.check_result(w);
      n_results++;
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = rx_free ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic send_word(input logic op, input logic [31:0] mx, my, mh, ms, mw,
                           input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    cfg_we <= 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_meas_x <= mx;
    in_meas_y <= my;
    in_meas_heading <= mh;
    in_meas_speed <= ms;
    in_meas_yaw_rate <= mw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, mx, my, mh, ms, mw);
    if (op == OP_SAMPLE) n_samples++;
    else n_ticks++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 4) - 2;
      3: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic sane_item(input int scale);
    logic [31:0] mx, my, mh;
    mx = sb.x_ref + $signed($urandom_range(0, scale << 1)) - scale;
    my = sb.y_ref + $signed($urandom_range(0, scale << 1)) - scale;
    mh = sb.head_ref + $signed($urandom_range(0, 40000)) - 20000;
    send_word(OP_SAMPLE, mx, my, mh, $urandom_range(0, 20 << 16),
              $signed($urandom_range(0, 1 << 17)) - (1 << 16));
    send_word(OP_TICK, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  initial begin
    logic [31:0] ext[5] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h1};
    logic [31:0] v;
    longint s, c, dy;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int i = 0; i < 5; i++) begin
      send_word(OP_SAMPLE, ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5],
                ext[(i + 3) % 5], ext[(i + 4) % 5]);
      send_word(OP_TICK, ext[i], ext[i], ext[i], ext[i], ext[i]);
    end
    rx_free = 1;
    for (int i = 0; i < 4; i++) sane_item(1 << 16);
    rx_free = 0;
    drain();

    write_reg(CFG_STEP_TIME, 32'd1);
    write_reg(CFG_TURN_START, 32'd0);
    write_reg(CFG_TGT_SPEED, 32'd0);
    send_word(OP_SAMPLE, 0, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0, 0);
    drain();
    // unit lateral error with unit curvature drives the denominator to zero
    write_reg(CFG_TURN_CURV, 32'd65536);
    rotate(sb.head_ref, s, c);
    dy = 65536;
    while (c > 0 && tm(c, dy) < 65536 && dy < 131072) dy++;
    send_word(OP_SAMPLE, 32'(sb.x_ref), 32'(sb.y_ref + dy), 32'(sb.head_ref),
              32'd65536, 0);
    send_word(OP_TICK, 0, 0, 0, 0, 0);
    drain();
    write_reg(CFG_STEP_TIME, 32'd65536);
    write_reg(CFG_TGT_SPEED, 32'd65536);
    write_reg(CFG_TURN_CURV, 32'd65536);
    write_reg(CFG_TURN_START, 32'd1638400);
    for (int i = 0; i < 28; i++) sane_item(1 << 16);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 8; r++) begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 32'hFFFFFFFF;
          2: v = $urandom_range(0, 1 << 17);
          default: v = $urandom();
        endcase
        if (r == CFG_STEP_TIME) v = (phase == 0) ? 32'd65536 :
                                    (phase == 1) ? 32'd1 : $urandom_range(1, 65536);
        if (r == CFG_TURN_START) v = (phase == 2) ? 32'd1638400 : $urandom_range(0, 1638400);
        if (r == CFG_TGT_SPEED || r == CFG_TURN_CURV)
          if (phase < 4) v = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        write_reg(3'(r), v);
      end
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 4) != 0) sane_item(phase < 4 ? (4 << 16) : (1 << 30));
        else send_word($urandom_range(0, 1), pick32(), pick32(), pick32(), pick32(),
                       pick32());
      end
      drain();
    end

    drain();
    $display("covered %0d state samples and %0d control ticks, %0d results checked",
             n_samples, n_ticks, n_results);
    $display("eight random register phases plus directed step, turn window and zero divisor setups");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

### path_following_steering_control_core.f
+incdir+hdl
hdl/pfsc_pkg.sv
hdl/pfsc_cordic.sv
hdl/pfsc_div.sv
hdl/path_following_steering_control_core.sv
hdl/pfsc_checker.sv
tb/path_following_steering_control_core_tb.sv
